### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### rtl/itids_pkg.sv
// Shared types, sizes and codes of the indexed table.
package itids_pkg;

   localparam int DEPTH     = 64;
   localparam int VALUE_W   = 32;
   localparam int OP_W      = 2;
   localparam int POS_IN_W  = 7;
   localparam int FOUND_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CMP_W     = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;
   localparam int POS_W     = $clog2(DEPTH);
   localparam int GRP       = 8;
   localparam int GI_W      = $clog2(GRP);
   localparam int NGRP      = (DEPTH + GRP - 1) / GRP;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GROUP,
      S_SELECT
   } state_type;

   typedef struct packed {
      logic               ins;
      logic               del;
      logic               search;
      logic [CMP_W-1:0]   pos;
      logic [CMP_W-1:0]   count;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] position;
   } match_type;

endpackage

### rtl/itids_cell.sv
// One table cell: holds an entry, shifts with its neighbors, flags a search hit.
module itids_cell (
   input  logic                          clock,
   input  itids_pkg::cell_ctrl_type      ctrl,
   input  logic [itids_pkg::CMP_W-1:0]   index,
   input  logic [itids_pkg::VALUE_W-1:0] below_entry,
   input  logic [itids_pkg::VALUE_W-1:0] above_entry,
   output logic [itids_pkg::VALUE_W-1:0] entry,
   output logic                          hit
);

   logic [itids_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                          hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (index > ctrl.pos) begin
            entry_in = below_entry;
         end else if (index == ctrl.pos) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.del) begin
         if (index >= ctrl.pos) begin
            entry_in = above_entry;
         end
      end
      hit_in = hit_ff;
      if (ctrl.search) begin
         hit_in = (index < ctrl.count) && (entry_ff == ctrl.value);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

### rtl/itids_prio.sv
// Registered two-level priority encoder over the cells' hit flags.
module itids_prio (
   input  logic                        clock,
   input  logic [itids_pkg::DEPTH-1:0] hits,
   output itids_pkg::match_type        match
);

   logic [itids_pkg::NGRP*itids_pkg::GRP-1:0] hits_pad;
   logic                                      grp_hit_ff [itids_pkg::NGRP];
   logic [itids_pkg::GI_W-1:0]                grp_idx_ff [itids_pkg::NGRP];
   logic                                      grp_hit_in [itids_pkg::NGRP];
   logic [itids_pkg::GI_W-1:0]                grp_idx_in [itids_pkg::NGRP];

   always_comb begin
      hits_pad = '0;
      hits_pad[itids_pkg::DEPTH-1:0] = hits;
   end

   // first level: lowest set flag inside each group of eight
   always_comb begin
      for (int g = 0; g < itids_pkg::NGRP; g++) begin
         grp_hit_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int k = itids_pkg::GRP - 1; k >= 0; k--) begin
            if (hits_pad[g*itids_pkg::GRP + k]) begin
               grp_hit_in[g] = 1'b1;
               grp_idx_in[g] = itids_pkg::GI_W'(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < itids_pkg::NGRP; g++) begin
         grp_hit_ff[g] <= grp_hit_in[g];
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   // second level: lowest group with a hit
   always_comb begin
      match.hit      = 1'b0;
      match.position = '0;
      for (int g = itids_pkg::NGRP - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            match.hit      = 1'b1;
            match.position = itids_pkg::POS_W'(g * itids_pkg::GRP + int'(grp_idx_ff[g]));
         end
      end
   end

endmodule

### rtl/indexed_table_insert_delete_search.sv
// Top level of the indexed table: control, count and response register.
//
// A packed table of up to 64 signed 32-bit values held in a row of cells.
// Insert and delete shift every cell at once; such an item is accepted and its
// result is registered at the same edge, so these operations run at one item
// per cycle while the response is taken. A search stalls new requests until
// answered: the cells compare in parallel at acceptance, then the match flags
// pass a registered two-level priority encoder, groups of eight then the group
// pick. Status codes: 0 ok, 1 bad index (also for operation code 3), 2 table
// full, 3 not found. Every result carries the entry count after the operation;
// found_position is zero unless a search hit.
module indexed_table_insert_delete_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_item_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_found_position,
   output logic [6:0]  rsp_entry_count
);

`include "assert_macros.svh"

   itids_pkg::state_type            state_ff, state_in;
   logic [itids_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      status_ff, status_in;
   logic [itids_pkg::FOUND_W-1:0]   found_ff, found_in;
   logic [itids_pkg::CNT_W-1:0]     rcount_ff, rcount_in;

   itids_pkg::cell_ctrl_type        ctrl;
   itids_pkg::match_type            match;
   logic [itids_pkg::VALUE_W-1:0]   entry_w [itids_pkg::DEPTH];
   logic [itids_pkg::DEPTH-1:0]     hits;

   logic                            accept;
   logic [itids_pkg::CMP_W-1:0]     pos_ext;
   logic [itids_pkg::CMP_W-1:0]     count_ext;
   logic                            full;
   logic [itids_pkg::POS_W+itids_pkg::FOUND_W-1:0]   found_wide;
   logic [itids_pkg::CNT_W+itids_pkg::COUNT_W-1:0]   count_wide;

   genvar gi;
   generate
      for (gi = 0; gi < itids_pkg::DEPTH; gi++) begin : g_cell
         logic [itids_pkg::VALUE_W-1:0] below, above;
         if (gi == 0) begin : g_first
            assign below = ctrl.value;
         end else begin : g_mid_lo
            assign below = entry_w[gi-1];
         end
         if (gi == itids_pkg::DEPTH - 1) begin : g_last
            assign above = entry_w[gi];
         end else begin : g_mid_hi
            assign above = entry_w[gi+1];
         end
         itids_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .index       (itids_pkg::CMP_W'(gi)),
            .below_entry (below),
            .above_entry (above),
            .entry       (entry_w[gi]),
            .hit         (hits[gi])
         );
      end
   endgenerate

   itids_prio u_prio (
      .clock (clock),
      .hits  (hits),
      .match (match)
   );

   assign req_ready = (state_ff == itids_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign pos_ext   = itids_pkg::CMP_W'(req_position);
   assign count_ext = itids_pkg::CMP_W'(count_ff);
   assign full      = (count_ff == itids_pkg::CNT_W'(itids_pkg::DEPTH));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      found_in     = found_ff;
      rcount_in    = rcount_ff;
      found_wide   = {{itids_pkg::FOUND_W{1'b0}}, match.position};

      ctrl.ins    = 1'b0;
      ctrl.del    = 1'b0;
      ctrl.search = 1'b0;
      ctrl.pos    = pos_ext;
      ctrl.count  = count_ext;
      ctrl.value  = req_item_value;

      case (state_ff)
         itids_pkg::S_IDLE: begin
            if (accept) begin
               found_in  = '0;
               rcount_in = count_ff;
               case (req_operation)
                  itids_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (pos_ext > count_ext) begin
                        status_in = itids_pkg::ST_BAD_INDEX;
                     end else if (full) begin
                        status_in = itids_pkg::ST_FULL;
                     end else begin
                        status_in = itids_pkg::ST_OK;
                        ctrl.ins  = 1'b1;
                        count_in  = count_ff + 1'b1;
                        rcount_in = count_ff + 1'b1;
                     end
                  end
                  itids_pkg::OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (pos_ext >= count_ext) begin
                        status_in = itids_pkg::ST_BAD_INDEX;
                     end else begin
                        status_in = itids_pkg::ST_OK;
                        ctrl.del  = 1'b1;
                        count_in  = count_ff - 1'b1;
                        rcount_in = count_ff - 1'b1;
                     end
                  end
                  itids_pkg::OP_SEARCH: begin
                     rsp_valid_in = 1'b0;
                     ctrl.search  = 1'b1;
                     state_in     = itids_pkg::S_GROUP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = itids_pkg::ST_BAD_INDEX;
                  end
               endcase
            end
         end
         itids_pkg::S_GROUP: begin
            state_in = itids_pkg::S_SELECT;
         end
         itids_pkg::S_SELECT: begin
            // hold the search result until the response register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rcount_in    = count_ff;
               if (match.hit) begin
                  status_in = itids_pkg::ST_OK;
                  found_in  = found_wide[itids_pkg::FOUND_W-1:0];
               end else begin
                  status_in = itids_pkg::ST_NOT_FOUND;
                  found_in  = '0;
               end
               state_in = itids_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = itids_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itids_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff  <= found_in;
      rcount_ff <= rcount_in;
   end

   assign count_wide         = {{itids_pkg::COUNT_W{1'b0}}, rcount_ff};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_entry_count    = count_wide[itids_pkg::COUNT_W-1:0];

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > itids_pkg::CNT_W'(itids_pkg::DEPTH))
   `ASSERT_HOLDS(a_search_blocks, clock, reset, (accept && req_operation == itids_pkg::OP_SEARCH) |=> !req_ready)
   `ASSERT_HOLDS(a_count_quiet, clock, reset, !accept |=> $stable(count_ff))
   `ASSERT_NEVER(a_busy_no_accept, clock, reset, (state_ff != itids_pkg::S_IDLE) && accept)

endmodule
